// ----- hw/rtl/lpdcc_pkg.sv -----
// Package: shared types and constants of the low-priority delay congestion controller.
package lpdcc_pkg;

   localparam int unsigned StampWidth = 32;
   localparam int unsigned CsrWidth   = 16;
   localparam int unsigned DivSteps   = 32;

   localparam logic [0:0]  CsrLocalTickRate   = 1'b0;
   localparam logic [0:0]  CsrDelayResolution = 1'b1;

   localparam logic [CsrWidth-1:0]   ResetTickRate   = 16'd1000;
   localparam logic [CsrWidth-1:0]   ResetResolution = 16'd1000;

   // Fifteen per cent of the range: times 15, then divided by 100 as a multiply by
   // ceil(2^37 / 100) and a shift by 37, which is exact for any 32-bit operand.
   localparam logic [StampWidth-1:0] ThreshScale = 32'd15;
   localparam logic [StampWidth-1:0] ThreshRecip = 32'h51EB_851F;
   localparam int unsigned           ThreshShift = 37;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RMUL,
      ST_RDIV_GO,
      ST_RDIV_WAIT,
      ST_RUPD,
      ST_Q1_GO,
      ST_Q1_WAIT,
      ST_Q2_GO,
      ST_Q2_WAIT,
      ST_M1,
      ST_M2,
      ST_DSUB,
      ST_TAIL,
      ST_TWAIT,
      ST_DECIDE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ----- hw/rtl/lpdcc_if.sv -----
// Interfaces: acknowledgment request channel and window response channel.
interface lpdcc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] remote_stamp;
   logic [31:0] echoed_stamp;
   logic [31:0] current_time;
   logic [31:0] window_in;
   logic        rtt_present;

   modport source (output valid, remote_stamp, echoed_stamp, current_time, window_in,
                   rtt_present, input ready);
   modport sink   (input valid, remote_stamp, echoed_stamp, current_time, window_in,
                   rtt_present, output ready);
endinterface

interface lpdcc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] window_out;
   logic        in_inference;
   logic        below_threshold;
   logic        window_cut;

   modport source (output valid, window_out, in_inference, below_threshold, window_cut,
                   input ready);
   modport sink   (input valid, window_out, in_inference, below_threshold, window_cut,
                   output ready);
endinterface

// ----- hw/rtl/low_priority_delay_congestion_ctrl.sv -----
// Top level: delay-based low-priority congestion window controller with a shared divider.
//
//  channel  direction  handshake     contents
//  req_ch   in         valid/ready   remote, echoed and current stamps, window, rtt flag
//  rsp_ch   out        valid/ready   window, inference, below-threshold and cut flags
//  csr_*    in         write enable  tick rate (index 0), delay resolution (index 1)
//
// An acknowledgment with an RTT sample may pass up to three times through the one iterative
// divider; one without an RTT sample goes straight to the threshold tail.
// One item is in work at a time; req ready is high only while the sequencer is idle.
// Reset is synchronous and restores the sequencer state, the CSRs and all delay state.
// A result waits in its output register until the transfer, stalling the sequencer.
module low_priority_delay_congestion_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   lpdcc_req_if.sink                         req_ch,
   lpdcc_rsp_if.source                       rsp_ch,
   input  logic                              csr_write_enable,
   input  logic [0:0]                        csr_index,
   input  logic [lpdcc_pkg::CsrWidth-1:0]    csr_write_data
);
   localparam int unsigned W = lpdcc_pkg::StampWidth;

   lpdcc_pkg::state_type state_ff, state_in;

   logic [lpdcc_pkg::CsrWidth-1:0] tick_rate_ff, resolution_ff;

   logic [W-1:0] rstamp_ff, estamp_ff, now_ff, win_ff;

   logic [W-1:0] rate_ff, rref_ff, lref_ff;
   logic [W-1:0] dmin_ff, dmax_ff, dres_ff, smooth_ff, lcut_ff, span_ff;
   logic [W-1:0] prod_ff, p1_ff, q1_ff, frac_ff;
   logic         infer_ff;

   logic [W-1:0] out_win_ff;
   logic         out_infer_ff, out_below_ff, out_cut_ff;

   // Shared multiplier operands and divider operands.
   logic [W-1:0] mul_a, mul_b;
   logic [2*W-1:0] mul_full;
   logic         div_start;
   logic [W-1:0] div_a, div_b, div_q;
   lpdcc_pkg::div_stat_type div_stat;

   logic         rate_cond;
   logic [W+6:0] rate_mix;
   logic [W-1:0] rate_new;
   logic [W-1:0] delay;
   logic [W-1:0] span_new;
   logic [W-1:0] sd, thr, half_win;
   logic         below;

   lpdcc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .quotient (div_q),
      .stat     (div_stat)
   );

   always_comb begin
      rate_cond = (rref_ff != '0) && (lref_ff != '0) &&
                  (rstamp_ff != rref_ff) && (estamp_ff != lref_ff);
      rate_mix  = {1'b0, rate_ff, 6'b0} - {7'b0, rate_ff} + {7'b0, div_q};
      if (!rate_cond)
         rate_new = rate_ff;
      else if (rate_ff == '0)
         rate_new = div_q;
      else
         rate_new = rate_mix[W+5:6];
      delay    = p1_ff - prod_ff;
      span_new = (now_ff > estamp_ff) ? (((now_ff - estamp_ff) << 1) + (now_ff - estamp_ff))
                                      : span_ff;
      sd       = smooth_ff >> 3;
      thr      = dmin_ff + frac_ff;
      below    = sd < thr;
      half_win = win_ff >> 1;
   end

   always_comb begin
      state_in  = state_ff;
      mul_a     = {{(W-lpdcc_pkg::CsrWidth){1'b0}}, tick_rate_ff};
      mul_b     = rstamp_ff - rref_ff;
      div_start = 1'b0;
      div_a     = prod_ff;
      div_b     = estamp_ff - lref_ff;
      case (state_ff)
         lpdcc_pkg::ST_IDLE: begin
            if (req_ch.valid)
               state_in = req_ch.rtt_present ? lpdcc_pkg::ST_RMUL : lpdcc_pkg::ST_TAIL;
         end
         lpdcc_pkg::ST_RMUL: begin
            state_in = rate_cond ? lpdcc_pkg::ST_RDIV_GO : lpdcc_pkg::ST_RUPD;
         end
         lpdcc_pkg::ST_RDIV_GO: begin
            div_start = 1'b1;
            state_in  = lpdcc_pkg::ST_RDIV_WAIT;
         end
         lpdcc_pkg::ST_RDIV_WAIT: begin
            if (div_stat.done) state_in = lpdcc_pkg::ST_RUPD;
         end
         lpdcc_pkg::ST_RUPD: begin
            state_in = (rate_new != '0) ? lpdcc_pkg::ST_Q1_GO : lpdcc_pkg::ST_TAIL;
         end
         lpdcc_pkg::ST_Q1_GO: begin
            div_start = 1'b1;
            div_a     = {{(W-lpdcc_pkg::CsrWidth){1'b0}}, resolution_ff};
            div_b     = rate_ff;
            state_in  = lpdcc_pkg::ST_Q1_WAIT;
         end
         lpdcc_pkg::ST_Q1_WAIT: begin
            if (div_stat.done) state_in = lpdcc_pkg::ST_Q2_GO;
         end
         lpdcc_pkg::ST_Q2_GO: begin
            div_start = 1'b1;
            div_a     = {{(W-lpdcc_pkg::CsrWidth){1'b0}}, resolution_ff};
            div_b     = {{(W-lpdcc_pkg::CsrWidth){1'b0}}, tick_rate_ff};
            state_in  = lpdcc_pkg::ST_Q2_WAIT;
         end
         lpdcc_pkg::ST_Q2_WAIT: begin
            mul_a = rstamp_ff;
            mul_b = q1_ff;
            if (div_stat.done) state_in = lpdcc_pkg::ST_M1;
         end
         lpdcc_pkg::ST_M1: begin
            mul_a    = estamp_ff;
            mul_b    = div_q;
            state_in = lpdcc_pkg::ST_DSUB;
         end
         lpdcc_pkg::ST_M2,
         lpdcc_pkg::ST_DSUB: begin
            state_in = lpdcc_pkg::ST_TAIL;
         end
         lpdcc_pkg::ST_TAIL: begin
            // Fifteen times the range goes into the product register first.
            mul_a    = dmax_ff - dmin_ff;
            mul_b    = lpdcc_pkg::ThreshScale;
            state_in = lpdcc_pkg::ST_TWAIT;
         end
         lpdcc_pkg::ST_TWAIT: begin
            mul_a    = prod_ff;
            mul_b    = lpdcc_pkg::ThreshRecip;
            state_in = lpdcc_pkg::ST_DECIDE;
         end
         lpdcc_pkg::ST_DECIDE: begin
            state_in = lpdcc_pkg::ST_OUT;
         end
         lpdcc_pkg::ST_OUT: begin
            if (rsp_ch.ready) state_in = lpdcc_pkg::ST_IDLE;
         end
         default: state_in = lpdcc_pkg::ST_IDLE;
      endcase
   end

   assign mul_full = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= lpdcc_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_rate_ff  <= lpdcc_pkg::ResetTickRate;
         resolution_ff <= lpdcc_pkg::ResetResolution;
      end else if (csr_write_enable) begin
         case (csr_index)
            lpdcc_pkg::CsrLocalTickRate:   tick_rate_ff  <= csr_write_data;
            lpdcc_pkg::CsrDelayResolution: resolution_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_full[W-1:0];
      if (state_ff == lpdcc_pkg::ST_IDLE && req_ch.valid) begin
         rstamp_ff <= req_ch.remote_stamp;
         estamp_ff <= req_ch.echoed_stamp;
         now_ff    <= req_ch.current_time;
         win_ff    <= req_ch.window_in;
      end
      if (state_ff == lpdcc_pkg::ST_Q1_WAIT && div_stat.done) q1_ff <= div_q;
      if (state_ff == lpdcc_pkg::ST_M1) p1_ff <= prod_ff;
      if (state_ff == lpdcc_pkg::ST_TWAIT)
         frac_ff <= {{(lpdcc_pkg::ThreshShift-W){1'b0}},
                     mul_full[2*W-1:lpdcc_pkg::ThreshShift]};
      if (state_ff == lpdcc_pkg::ST_DECIDE) begin
         out_infer_ff <= infer_ff;
         out_below_ff <= below;
         out_cut_ff   <= !below;
         if (below)                 out_win_ff <= win_ff;
         else if (infer_ff)         out_win_ff <= 32'd1;
         else if (half_win > 32'd1) out_win_ff <= half_win;
         else                       out_win_ff <= 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff   <= '0;
         rref_ff   <= '0;
         lref_ff   <= '0;
         dmin_ff   <= '1;
         dmax_ff   <= '0;
         dres_ff   <= '0;
         smooth_ff <= '0;
         lcut_ff   <= '0;
         span_ff   <= '0;
         infer_ff  <= 1'b0;
      end else begin
         case (state_ff)
            lpdcc_pkg::ST_RUPD: begin
               rate_ff <= rate_new;
               rref_ff <= rstamp_ff;
               lref_ff <= estamp_ff;
            end
            lpdcc_pkg::ST_DSUB: begin
               // The rate is known to be nonzero here; only a nonzero delay counts.
               if (delay != '0) begin
                  if (delay < dmin_ff) dmin_ff <= delay;
                  if (delay > dmax_ff) begin
                     if (delay > dres_ff) begin
                        dmax_ff <= (dres_ff == '0) ? delay : dres_ff;
                        dres_ff <= delay;
                     end else begin
                        dmax_ff <= delay;
                     end
                  end
                  if (smooth_ff != '0) smooth_ff <= smooth_ff + delay - (smooth_ff >> 3);
                  else                 smooth_ff <= delay << 3;
               end
            end
            lpdcc_pkg::ST_TAIL: begin
               span_ff  <= span_new;
               infer_ff <= (lcut_ff != '0) && ((now_ff - lcut_ff) < span_new);
            end
            lpdcc_pkg::ST_DECIDE: begin
               if (!below) begin
                  dmin_ff <= sd;
                  dmax_ff <= smooth_ff >> 2;
                  dres_ff <= smooth_ff >> 2;
                  lcut_ff <= now_ff;
               end
            end
            default: ;
         endcase
      end
   end

   assign req_ch.ready           = (state_ff == lpdcc_pkg::ST_IDLE);
   assign rsp_ch.valid           = (state_ff == lpdcc_pkg::ST_OUT);
   assign rsp_ch.window_out      = out_win_ff;
   assign rsp_ch.in_inference    = out_infer_ff;
   assign rsp_ch.below_threshold = out_below_ff;
   assign rsp_ch.window_cut      = out_cut_ff;

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid)) else $error("ready while a result is held");
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !div_stat.busy) else $error("divider busy while idle");
   a_cut_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.window_cut != rsp_ch.below_threshold))
      else $error("cut and below-threshold disagree");
   a_cut_window: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.window_cut && rsp_ch.in_inference |-> rsp_ch.window_out == 32'd1)
      else $error("inference cut did not give a window of one");
endmodule

// ----- hw/rtl/lpdcc_div.sv -----
// Iterative restoring divider, one quotient bit per cycle; a zero divisor gives all ones.
module lpdcc_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [lpdcc_pkg::StampWidth-1:0]    dividend,
   input  logic [lpdcc_pkg::StampWidth-1:0]    divisor,
   output logic [lpdcc_pkg::StampWidth-1:0]    quotient,
   output lpdcc_pkg::div_stat_type             stat
);
   localparam int unsigned W  = lpdcc_pkg::StampWidth;
   localparam int unsigned CW = $clog2(lpdcc_pkg::DivSteps + 1);

   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W:0]    shifted;
   logic [W:0]    trial;

   always_comb begin
      shifted = {rem_ff, quo_ff[W-1]};
      trial   = shifted - {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CW'(lpdcc_pkg::DivSteps);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = shifted[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff)) else $error("divider done without run");
   a_count_live: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0) else $error("divider running with empty count");
endmodule

// ----- verif/low_priority_delay_congestion_ctrl_tb.sv -----
// Testbench: checks the congestion window controller against a built-in predictor.
module low_priority_delay_congestion_ctrl_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned IdleLimit   = 6000;
   localparam int unsigned SettleTicks = 150;

   typedef struct packed {
      logic [31:0] remote_stamp;
      logic [31:0] echoed_stamp;
      logic [31:0] current_time;
      logic [31:0] window_in;
      logic        rtt_present;
   } ack_type;

   typedef struct packed {
      logic [31:0] window_out;
      logic        in_inference;
      logic        below_threshold;
      logic        window_cut;
   } window_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic [0:0] csr_index;
   logic [lpdcc_pkg::CsrWidth-1:0] csr_write_data;

   lpdcc_req_if req_ch ();
   lpdcc_rsp_if rsp_ch ();

   low_priority_delay_congestion_ctrl dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor state and its copy of the registers.
   logic [31:0] tick_rate, resolution;
   logic [31:0] rate_est, remote_ref, local_ref;
   logic [31:0] min_delay, max_delay, max_reserve, smooth_x8, last_cut, infer_span;

   window_type window_due_q[$];
   bit      failed = 1'b0;
   int      burst_left = 0;
   int      idle_count = 0;
   int      stall_cycle = 0;
   int      stall_mode = 0;
   logic [31:0] seq_remote, seq_echoed;

   function automatic logic [31:0] div_or_ones(input logic [31:0] a, input logic [31:0] b);
      return (b != 0) ? a / b : 32'hffff_ffff;
   endfunction

   task automatic predict_window(input ack_type a, output window_type w);
      logic [31:0] num, den, sample, d, sd, thr, since, win;
      logic [63:0] acc;
      logic        infer, below, cut;
      win = a.window_in;
      cut = 1'b0;
      if (a.rtt_present) begin
         if (remote_ref != 0 && local_ref != 0 && a.remote_stamp != remote_ref &&
             a.echoed_stamp != local_ref) begin
            num = tick_rate * (a.remote_stamp - remote_ref);
            den = a.echoed_stamp - local_ref;
            sample = num / den;
            if (rate_est != 0) begin
               acc = {32'd0, rate_est} * 64'd63 + {32'd0, sample};
               rate_est = acc[37:6];
            end else begin
               rate_est = sample;
            end
         end
         remote_ref = a.remote_stamp;
         local_ref  = a.echoed_stamp;
         d = 32'd0;
         if (rate_est != 0)
            d = a.remote_stamp * div_or_ones(resolution, rate_est) -
                a.echoed_stamp * div_or_ones(resolution, tick_rate);
         if (rate_est != 0 && d != 0) begin
            if (d < min_delay) min_delay = d;
            if (d > max_delay) begin
               if (d > max_reserve) begin
                  max_delay   = (max_reserve == 0) ? d : max_reserve;
                  max_reserve = d;
               end else begin
                  max_delay = d;
               end
            end
            if (smooth_x8 != 0) smooth_x8 = smooth_x8 + d - (smooth_x8 >> 3);
            else smooth_x8 = d << 3;
         end
      end
      if (a.current_time > a.echoed_stamp)
         infer_span = 32'd3 * (a.current_time - a.echoed_stamp);
      since = a.current_time - last_cut;
      infer = (last_cut != 0) && (since < infer_span);
      sd  = smooth_x8 >> 3;
      thr = min_delay + (32'd15 * (max_delay - min_delay)) / 32'd100;
      below = sd < thr;
      if (!below) begin
         min_delay   = sd;
         max_delay   = smooth_x8 >> 2;
         max_reserve = smooth_x8 >> 2;
         if (infer) win = 32'd1;
         else win = ((win >> 1) > 1) ? (win >> 1) : 32'd1;
         last_cut = a.current_time;
         cut = 1'b1;
      end
      w = '{win, infer, below, cut};
   endtask

   // Sender: bursts of random length separated by random gaps.
   task automatic send_ack(input ack_type a);
      window_type w;
      int gap;
      if (burst_left == 0) begin
         burst_left = (($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 12));
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid        <= 1'b1;
      req_ch.remote_stamp <= a.remote_stamp;
      req_ch.echoed_stamp <= a.echoed_stamp;
      req_ch.current_time <= a.current_time;
      req_ch.window_in    <= a.window_in;
      req_ch.rtt_present  <= a.rtt_present;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_window(a, w);
      window_due_q.push_back(w);
   endtask

   // Lowers valid and waits until every result is back and the sequencer has settled.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (window_due_q.size() != 0) @(posedge clock);
      repeat (SettleTicks) @(posedge clock);
   endtask

   task automatic write_csr(input logic [0:0] idx,
                            input logic [lpdcc_pkg::CsrWidth-1:0] val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == lpdcc_pkg::CsrLocalTickRate) tick_rate = {16'd0, val};
      else resolution = {16'd0, val};
   endtask

   function automatic ack_type noise_ack();
      ack_type a;
      a.remote_stamp = $urandom;
      a.echoed_stamp = $urandom;
      a.current_time = ($urandom_range(0, 1) == 1) ? a.echoed_stamp + $urandom_range(0, 9000)
                                                   : $urandom;
      a.window_in    = ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 64);
      a.rtt_present  = 1'($urandom_range(0, 1));
      return a;
   endfunction

   // Consecutive acknowledgments with advancing stamps, so that a rate estimate forms.
   function automatic ack_type flow_ack();
      ack_type a;
      seq_remote = seq_remote + (($urandom_range(0, 9) == 0) ? $urandom_range(1, 60000)
                                                             : $urandom_range(1, 2000));
      seq_echoed = seq_echoed + $urandom_range(1, 2000);
      if (seq_remote == 0) seq_remote = 1;
      if (seq_echoed == 0) seq_echoed = 1;
      a.remote_stamp = seq_remote;
      a.echoed_stamp = seq_echoed;
      a.current_time = seq_echoed + (($urandom_range(0, 15) == 0) ? $urandom
                                                                  : $urandom_range(0, 6000));
      a.window_in    = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 200);
      a.rtt_present  = ($urandom_range(0, 7) != 0);
      return a;
   endfunction

   task automatic run_random(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 15) send_ack(noise_ack());
         else send_ack(flow_ack());
      end
   endtask

   task automatic test_directed();
      ack_type a;
      send_ack('{32'h0, 32'h0, 32'h0, 32'h0, 1'b1});
      send_ack('{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1});
      send_ack('{32'h100, 32'h100, 32'h200, 32'd1, 1'b1});
      send_ack('{32'h200, 32'h180, 32'h300, 32'd0, 1'b1});
      send_ack('{32'h300, 32'h200, 32'h100, 32'd8, 1'b1});
      send_ack('{32'h400, 32'h280, 32'h400, 32'd16, 1'b0});
      send_ack('{32'h400, 32'h300, 32'h500, 32'd3, 1'b1});
      send_ack('{32'h500, 32'h300, 32'h600, 32'd2, 1'b1});
      send_ack('{32'h1500, 32'h400, 32'h700, 32'h8000_0000, 1'b1});
      send_ack('{32'h1600, 32'h500, 32'h501, 32'h7fff_ffff, 1'b1});
      send_ack('{32'h0, 32'h600, 32'h700, 32'd1, 1'b1});
      send_ack('{32'haaaa_aaaa, 32'h5555_5555, 32'hffff_ffff, 32'd100, 1'b1});
      send_ack('{32'h5555_5555, 32'haaaa_aaaa, 32'h0, 32'd100, 1'b1});
      seq_remote = 32'h10; seq_echoed = 32'h10;
      for (int i = 0; i < 10; i++) begin
         a = flow_ack();
         send_ack(a);
      end
   endtask

   task automatic test_extreme_config();
      drain_results();
      write_csr(lpdcc_pkg::CsrLocalTickRate, 16'd1);
      write_csr(lpdcc_pkg::CsrDelayResolution, 16'hffff);
      run_random(300);
      drain_results();
      write_csr(lpdcc_pkg::CsrLocalTickRate, 16'hffff);
      write_csr(lpdcc_pkg::CsrDelayResolution, 16'd1);
      run_random(200);
   endtask

   task automatic test_random_config();
      for (int p = 0; p < 3; p++) begin
         drain_results();
         write_csr(lpdcc_pkg::CsrLocalTickRate, 16'($urandom_range(1, 65535)));
         write_csr(lpdcc_pkg::CsrDelayResolution, 16'($urandom_range(1, 65535)));
         run_random(150);
      end
      drain_results();
      write_csr(lpdcc_pkg::CsrLocalTickRate, 16'd1000);
      write_csr(lpdcc_pkg::CsrDelayResolution, 16'd1000);
      run_random(150);
   endtask

   // Result side: stalls on its own pattern, and every transfer is checked in order.
   always @(posedge clock) begin
      window_type w;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (window_due_q.size() == 0) begin
            $display("%0t: unexpected result window_out %0d", $time, rsp_ch.window_out);
            failed = 1'b1;
         end else begin
            w = window_due_q.pop_front();
            if (rsp_ch.window_out !== w.window_out) begin
               $display("%0t: window_out expected %0d actual %0d",
                        $time, w.window_out, rsp_ch.window_out);
               failed = 1'b1;
            end
            if (rsp_ch.in_inference !== w.in_inference) begin
               $display("%0t: in_inference expected %0b actual %0b",
                        $time, w.in_inference, rsp_ch.in_inference);
               failed = 1'b1;
            end
            if (rsp_ch.below_threshold !== w.below_threshold) begin
               $display("%0t: below_threshold expected %0b actual %0b",
                        $time, w.below_threshold, rsp_ch.below_threshold);
               failed = 1'b1;
            end
            if (rsp_ch.window_cut !== w.window_cut) begin
               $display("%0t: window_cut expected %0b actual %0b",
                        $time, w.window_cut, rsp_ch.window_cut);
               failed = 1'b1;
            end
         end
      end
      stall_cycle++;
      if (stall_cycle % 97 == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_ch.ready <= 1'b1;
         1: rsp_ch.ready <= 1'($urandom_range(0, 1));
         default: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_count <= 0;
      end else if (idle_count >= IdleLimit) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

   initial begin
      reset               <= 1'b1;
      csr_write_enable    <= 1'b0;
      csr_index           <= lpdcc_pkg::CsrLocalTickRate;
      csr_write_data      <= '0;
      req_ch.valid        <= 1'b0;
      req_ch.remote_stamp <= '0;
      req_ch.echoed_stamp <= '0;
      req_ch.current_time <= '0;
      req_ch.window_in    <= '0;
      req_ch.rtt_present  <= 1'b0;
      tick_rate = 32'd1000;  resolution = 32'd1000;
      rate_est = '0;  remote_ref = '0;  local_ref = '0;
      min_delay = 32'hffff_ffff;  max_delay = '0;  max_reserve = '0;
      smooth_x8 = '0;  last_cut = '0;  infer_span = '0;
      seq_remote = 32'd1;  seq_echoed = 32'd1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      run_random(180);
      test_extreme_config();
      test_random_config();
      drain_results();
      if (failed) begin
         $display("Simulation FAILED");
      end else begin
         $display("Simulation PASSED");
      end
      $finish;
   end
endmodule

// ----- filelist.f -----
hw/rtl/lpdcc_pkg.sv
hw/rtl/lpdcc_if.sv
hw/rtl/lpdcc_div.sv
hw/rtl/low_priority_delay_congestion_ctrl.sv
verif/low_priority_delay_congestion_ctrl_tb.sv
